/* rtl/sob_pkg.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types and constants for the RGB Sobel magnitude block.
// ----------------------------------------------------------------------------
package sob_pkg;

  localparam int PIX_W   = 8;
  localparam int RGB_W   = 3 * PIX_W;
  localparam int LANES   = 3;
  localparam int GRAD_W  = 11;
  localparam int ABS_W   = 10;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int ROOT_IN_W = 2 * PIX_W;
  localparam int REM_W   = 11;

  localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(64770);
  localparam logic [PIX_W-1:0] MAG_MAX   = 8'd255;

  localparam int FW_W = 11;
  localparam int FH_W = 13;
  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  localparam int ADDR_W = 3;
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  localparam logic ACT_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_SQ   = 4'b0010,
    L_ROOT = 4'b0100,
    L_FIN  = 4'b1000
  } lane_state_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_START = 5'b00100,
    S_CALC  = 5'b01000,
    S_OUT   = 5'b10000
  } top_state_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] mag;
  } lane_res_t;

endpackage

/* rtl/sob_if.sv */
// ----------------------------------------------------------------------------
// Sobel stream interfaces
// Valid/ready channels for incoming pixels and outgoing magnitudes.
// ----------------------------------------------------------------------------
interface sob_pix_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, action, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

interface sob_mag_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       end_of_frame;
  modport source (output valid, out_red, out_green, out_blue, end_of_frame, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, end_of_frame, output ready);
endinterface

/* rtl/sobel_edge_magnitude_rgb.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// Streaming 3x3 Sobel gradient magnitude on 8-bit RGB pixels.
//
// Pixels enter on the pixels channel in raster order; action high marks a
// flush item. Each result belongs to the pixel frame_width+1 items earlier,
// so after a frame the source sends frame_width+1 flush items. Results
// leave on the edges channel with end_of_frame on the frame's last pixel.
// An item that yields a result passes the shift, start, calc and out states,
// one that yields none only shift; the 8-step root iteration of the three
// lanes sets calc's length. One item is worked on at a time; the next is
// taken while a finished result waits in the output register, but a
// second result stalls until the edges sink takes the first.
// frame_width and frame_height are written through the APB port; the user
// must write them only while the block is idle, and the block itself does
// not enforce this; a write restarts the frame. Reset clears the position
// counters and the window and sets width 640, height 480; the line store
// needs no clearing.
module sobel_edge_magnitude_rgb
  import sob_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  sob_pix_if.sink           pixels,
  sob_mag_if.source         edges
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [WW-1:0]   w;
  logic [HW-1:0]   h;
  logic            cfg_wr;
  reg_index_t      cfg_idx;

  top_state_t      state;
  logic [1:0]      in_row;
  logic [CW-1:0]   in_col;
  logic [RW-1:0]   out_row;
  logic [CW-1:0]   out_col;
  logic [CW-1:0]   col_eff, col_l;
  logic [RGB_W-1:0] pix_l;
  logic            emit_l;
  logic            accept;
  logic            col_last;

  logic [RGB_W-1:0]   win [9];
  logic [2*RGB_W-1:0] ram_rdata;
  logic [RGB_W-1:0]   top_px, mid_px;

  logic            top_z, bot_z, left_z, right_z, eof_now, eof_l;
  logic [RGB_W-1:0] tap_m [9];
  logic [PIX_W-1:0] lane_taps [LANES][9];
  lane_res_t        lane_r [LANES];
  logic             lane_start;

  logic             ov;
  logic [PIX_W-1:0] o_red, o_green, o_blue;
  logic             o_eof;

  // configuration
  assign pready  = 1'b1;
  assign cfg_idx = reg_index_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0)                     w = WW'(1);
    else if (32'(frame_width) > MAX_WIDTH)     w = WW'(MAX_WIDTH);
    else                                       w = WW'(frame_width);
    if (frame_height == '0)                    h = HW'(1);
    else if (32'(frame_height) > MAX_HEIGHT)   h = HW'(MAX_HEIGHT);
    else                                       h = HW'(frame_height);
  end

  // input side
  assign pixels.ready = (state == S_IDLE);
  assign accept       = pixels.valid && pixels.ready;
  assign col_eff      = (WW'(in_col) >= w) ? '0 : in_col;
  assign col_last     = (WW'(col_eff) + WW'(1)) >= w;
  assign top_px       = ram_rdata[2*RGB_W-1:RGB_W];
  assign mid_px       = ram_rdata[RGB_W-1:0];

  sob_ram #(.WIDTH(2 * RGB_W), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (state == S_SHIFT),
    .waddr (col_l),
    .wdata ({mid_px, pix_l}),
    .raddr (col_eff),
    .rdata (ram_rdata)
  );

  // frame border masks
  always_comb begin
    top_z   = (out_row == '0);
    bot_z   = (HW'(out_row) + HW'(1)) >= h;
    left_z  = (out_col == '0);
    right_z = (WW'(out_col) + WW'(1)) >= w;
    eof_now = bot_z && right_z;
    for (int k = 0; k < 9; k++) begin
      if ((k / 3 == 0 && top_z) || (k / 3 == 2 && bot_z) ||
          (k % 3 == 0 && left_z) || (k % 3 == 2 && right_z)) begin
        tap_m[k] = '0;
      end else begin
        tap_m[k] = win[k];
      end
    end
    for (int l = 0; l < LANES; l++) begin
      for (int k = 0; k < 9; k++) begin
        lane_taps[l][k] = tap_m[k][RGB_W-1-PIX_W*l -: PIX_W];
      end
    end
  end

  assign lane_start = (state == S_START);

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    sob_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (lane_start),
      .taps  (lane_taps[l]),
      .res   (lane_r[l])
    );
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      ov      <= 1'b0;
      for (int k = 0; k < 9; k++) win[k] <= '0;
    end else begin
      if (ov && edges.ready) ov <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state  <= S_SHIFT;
            emit_l <= (in_row == 2'd2) || (in_row == 2'd1 && col_eff != '0);
            if (col_last) begin
              in_col <= '0;
              if (in_row != 2'd2) in_row <= in_row + 2'd1;
            end else begin
              in_col <= col_eff + CW'(1);
            end
          end
        end
        S_SHIFT: begin
          for (int r = 0; r < 3; r++) begin
            win[r*3]   <= win[r*3+1];
            win[r*3+1] <= win[r*3+2];
          end
          win[2] <= top_px;
          win[5] <= mid_px;
          win[8] <= pix_l;
          state  <= emit_l ? S_START : S_IDLE;
        end
        S_START: begin
          eof_l <= eof_now;
          if (eof_now) begin
            in_row  <= '0;
            in_col  <= '0;
            out_row <= '0;
            out_col <= '0;
          end else if (right_z) begin
            out_col <= '0;
            out_row <= out_row + RW'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
          state <= S_CALC;
        end
        S_CALC: if (lane_r[0].done) state <= S_OUT;
        S_OUT: begin
          if (!ov || edges.ready) begin
            ov      <= 1'b1;
            o_red   <= lane_r[0].mag;
            o_green <= lane_r[1].mag;
            o_blue  <= lane_r[2].mag;
            o_eof   <= eof_l;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_wr) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_l <= col_eff;
      pix_l <= (pixels.action == ACT_FLUSH) ? '0 :
               {pixels.in_red, pixels.in_green, pixels.in_blue};
    end
  end

  assign edges.valid        = ov;
  assign edges.out_red      = o_red;
  assign edges.out_green    = o_green;
  assign edges.out_blue     = o_blue;
  assign edges.end_of_frame = o_eof;

  a_accept_shift: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_SHIFT) else $error("accepted item did not advance");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    lane_r[0].done |-> lane_r[1].done && lane_r[2].done)
    else $error("lanes out of step");

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    (state == S_START && eof_now && !cfg_wr) |=> out_row == '0 && out_col == '0 && in_col == '0)
    else $error("frame did not restart after last pixel");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!ov || edges.ready)) |=> ov && state == S_IDLE)
    else $error("result not loaded");
endmodule

/* rtl/sob_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sob_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/sob_lane.sv */
// ----------------------------------------------------------------------------
// Sobel lane
// Gradients, squared sum and rounded root for one colour channel.
// ----------------------------------------------------------------------------
module sob_lane
  import sob_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [PIX_W-1:0] taps [9],
  output lane_res_t        res
);
  lane_state_t state;
  logic [ABS_W-1:0]     ax, ay;
  logic [ROOT_IN_W-1:0] m;
  logic                 sat;
  logic [REM_W-1:0]     rem;
  logic [PIX_W-1:0]     root;
  logic [2:0]           cnt;

  logic signed [GRAD_W-1:0] p [9];
  logic signed [GRAD_W-1:0] gx, gy;
  logic [SQ_W-1:0]          sqx, sqy;
  logic [SUM_W-1:0]         msum;
  logic [REM_W-1:0]         rem_sh, trial;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = $signed({3'b000, taps[i]});
    end
    gx = -p[0] + p[2] - (p[3] <<< 1) + (p[5] <<< 1) - p[6] + p[8];
    gy = -p[0] - (p[1] <<< 1) - p[2] + p[6] + (p[7] <<< 1) + p[8];
    sqx = ax * ax;
    sqy = ay * ay;
    msum = SUM_W'(sqx) + SUM_W'(sqy);
    rem_sh = {rem[REM_W-3:0], m[ROOT_IN_W-1 -: 2]};
    trial = {1'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: if (start) state <= L_SQ;
        L_SQ:   state <= L_ROOT;
        L_ROOT: if (cnt == 3'd0) state <= L_FIN;
        L_FIN:  state <= L_IDLE;
        default: state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        ax <= gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
        ay <= gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
      end
      L_SQ: begin
        sat  <= msum > SAT_LIMIT;
        m    <= msum[ROOT_IN_W-1:0];
        rem  <= '0;
        root <= '0;
        cnt  <= 3'd7;
      end
      L_ROOT: begin
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[PIX_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[PIX_W-2:0], 1'b0};
        end
        m   <= m << 2;
        cnt <= cnt - 3'd1;
      end
      default: ;
    endcase
  end

  assign res.done = (state == L_FIN);
  assign res.mag  = sat ? MAG_MAX :
                    (rem > REM_W'(root)) ? root + PIX_W'(1) : root;
endmodule
